// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define GAWP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define GAWP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gawp_pkg.sv -----
// ----------------------------------------------------------------------------
// gawp_pkg
// Types, codes and constants shared by the G-code axis word parser.
// ----------------------------------------------------------------------------
package gawp_pkg;

	// Defaults for the top-level parameters
	localparam int MaxWordLenDef     = 20;
	localparam int FractionDigitsDef = 4;
	localparam int ValueBitsDef      = 48;

	// Fixed width of the position ports
	localparam int OutW = 48;

	// Characters that steer the parser
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChOpen    = 8'h28;
	localparam logic [7:0] ChClose   = 8'h29;
	localparam logic [7:0] ChPoint   = 8'h2E;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_AXIS  = 2'd1,
		ERR_TOO_LONG = 2'd2,
		ERR_NO_VALUE = 2'd3
	} err_t;

	// Byte classes produced by the front end
	typedef enum logic [2:0] {
		CLS_OTHER   = 3'd0,
		CLS_NEWLINE = 3'd1,
		CLS_OPEN    = 3'd2,
		CLS_CLOSE   = 3'd3,
		CLS_AXIS    = 3'd4,
		CLS_DIGIT   = 3'd5,
		CLS_POINT   = 3'd6
	} cls_t;

	// One classified byte
	typedef struct packed {
		cls_t        cls;
		axis_t       axis;
		logic [3:0]  digit;
		logic        last;
	} item_t;

	// One result of a parse request
	typedef struct packed {
		logic [OutW-1:0] pos_x;
		logic [OutW-1:0] pos_y;
		logic [OutW-1:0] pos_z;
		err_t            err;
	} result_t;

	// Powers of ten for digit weights (up to 10^7, fits 24 bits)
	function automatic logic [23:0] pow10(input logic [2:0] k);
		logic [23:0] p;
		case (k)
			3'd0:    p = 24'd1;
			3'd1:    p = 24'd10;
			3'd2:    p = 24'd100;
			3'd3:    p = 24'd1000;
			3'd4:    p = 24'd10000;
			3'd5:    p = 24'd100000;
			3'd6:    p = 24'd1000000;
			default: p = 24'd10000000;
		endcase
		return p;
	endfunction

endpackage

// ----- src/gawp_queue.sv -----
// ----------------------------------------------------------------------------
// gawp_queue
// Two-entry first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module gawp_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] slot0_q;
	logic [W-1:0] slot1_q;
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_wr;
	logic         do_rd;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign rd_data = rd_ptr_q ? slot1_q : slot0_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr && !wr_ptr_q) begin
			slot0_q <= wr_data;
		end
		if (do_wr && wr_ptr_q) begin
			slot1_q <= wr_data;
		end
	end

endmodule

// ----- src/gawp_front.sv -----
// ----------------------------------------------------------------------------
// gawp_front
// Classifies each incoming byte and queues it for the executing stage.
// ----------------------------------------------------------------------------
module gawp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	output gawp_pkg::item_t item,
	output logic            item_valid,
	input  logic            item_take
);

	localparam int ItemW = $bits(gawp_pkg::item_t);

	gawp_pkg::item_t  cls_item;
	logic [ItemW-1:0] q_rd_data;
	logic             q_empty;

	// Byte classification
	always_comb begin
		cls_item.cls   = gawp_pkg::CLS_OTHER;
		cls_item.axis  = gawp_pkg::AXIS_NONE;
		cls_item.digit = 4'(data_byte - gawp_pkg::ChZero);
		cls_item.last  = last_byte;
		if (data_byte == gawp_pkg::ChNewline) begin
			cls_item.cls = gawp_pkg::CLS_NEWLINE;
		end else if (data_byte == gawp_pkg::ChOpen) begin
			cls_item.cls = gawp_pkg::CLS_OPEN;
		end else if (data_byte == gawp_pkg::ChClose) begin
			cls_item.cls = gawp_pkg::CLS_CLOSE;
		end else if (data_byte == gawp_pkg::ChPoint) begin
			cls_item.cls = gawp_pkg::CLS_POINT;
		end else if (data_byte inside {[gawp_pkg::ChZero:gawp_pkg::ChNine]}) begin
			cls_item.cls = gawp_pkg::CLS_DIGIT;
		end else if (data_byte inside {8'h58, 8'h78}) begin
			cls_item.cls  = gawp_pkg::CLS_AXIS;
			cls_item.axis = gawp_pkg::AXIS_X;
		end else if (data_byte inside {8'h59, 8'h79}) begin
			cls_item.cls  = gawp_pkg::CLS_AXIS;
			cls_item.axis = gawp_pkg::AXIS_Y;
		end else if (data_byte inside {8'h5A, 8'h7A}) begin
			cls_item.cls  = gawp_pkg::CLS_AXIS;
			cls_item.axis = gawp_pkg::AXIS_Z;
		end
	end

	// Queue between classifier and executor
	gawp_queue #(
		.W(ItemW)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cls_item),
		.rd_en  (item_take),
		.rd_data(q_rd_data),
		.full   (full),
		.empty  (q_empty)
	);

	assign item       = gawp_pkg::item_t'(q_rd_data);
	assign item_valid = !q_empty;

endmodule

// ----- src/gawp_exec.sv -----
// ----------------------------------------------------------------------------
// gawp_exec
// Runs the word state for each classified byte and keeps the axis positions.
// ----------------------------------------------------------------------------
module gawp_exec #(
	parameter int MAX_WORD_LEN    = gawp_pkg::MaxWordLenDef,
	parameter int FRACTION_DIGITS = gawp_pkg::FractionDigitsDef,
	parameter int VALUE_BITS      = gawp_pkg::ValueBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gawp_pkg::item_t   item,
	input  logic              item_valid,
	output logic              item_take,
	output gawp_pkg::result_t res,
	output logic              res_push,
	input  logic              res_full
);

	localparam int               VB      = VALUE_BITS;
	localparam int               OutPad  = gawp_pkg::OutW;
	localparam int               WCW     = $clog2(MAX_WORD_LEN);
	localparam logic [WCW-1:0]   WcLimit = WCW'(MAX_WORD_LEN - 1);
	localparam logic [2:0]       FdCnt   = 3'(FRACTION_DIGITS);
	localparam logic [23:0]      IntStep = gawp_pkg::pow10(FdCnt);
	localparam logic [VB-1:0]    ValMax  = {VB{1'b1}};

	// Parser state; scaled holds the open value already in final units
	typedef struct packed {
		gawp_pkg::axis_t open_axis;
		logic [WCW-1:0]  word_chars;
		logic            point_seen;
		logic            stopped;
		logic [2:0]      frac_count;
		logic [VB-1:0]   scaled;
		gawp_pkg::err_t  err;
		logic [VB-1:0]   pos_x;
		logic [VB-1:0]   pos_y;
		logic [VB-1:0]   pos_z;
	} pst_t;

	pst_t              st_q;
	pst_t              nx;
	logic              in_comment_q;
	logic              nx_comment;
	logic [23:0]       int_add;
	logic [23:0]       frac_add;
	logic [2:0]        frac_idx;
	logic [VB+4:0]     int_sum;
	logic [VB:0]       frac_sum;
	logic [VB-1:0]     scaled_int;
	logic [VB-1:0]     scaled_frac;
	logic [VB+OutPad-1:0] ext_x;
	logic [VB+OutPad-1:0] ext_y;
	logic [VB+OutPad-1:0] ext_z;

	// Write the open word to its axis, or flag an empty word, then close it
	function automatic pst_t commit_word(input pst_t s);
		pst_t r;
		r = s;
		if (s.open_axis != gawp_pkg::AXIS_NONE) begin
			if (s.word_chars == '0) begin
				r.err = gawp_pkg::ERR_NO_VALUE;
			end else begin
				case (s.open_axis)
					gawp_pkg::AXIS_X: r.pos_x = s.scaled;
					gawp_pkg::AXIS_Y: r.pos_y = s.scaled;
					default:          r.pos_z = s.scaled;
				endcase
			end
			r.open_axis  = gawp_pkg::AXIS_NONE;
			r.word_chars = '0;
			r.point_seen = 1'b0;
			r.stopped    = 1'b0;
			r.frac_count = 3'd0;
			r.scaled     = '0;
		end
		return r;
	endfunction

	assign item_take = item_valid && !res_full;
	assign res_push  = item_take && item.last;

	// Integer digit: value times ten plus the digit's full weight, saturated
	assign int_add    = 24'(28'(item.digit) * 28'(IntStep));
	assign int_sum    = ({5'd0, st_q.scaled} << 3) + ({5'd0, st_q.scaled} << 1)
		+ (VB+5)'(int_add);
	assign scaled_int = (|int_sum[VB+4:VB]) ? ValMax : int_sum[VB-1:0];

	// Fraction digit: add the digit at its place weight, saturated
	assign frac_idx    = FdCnt - 3'd1 - st_q.frac_count;
	assign frac_add    = 24'(28'(item.digit) * 28'(gawp_pkg::pow10(frac_idx)));
	assign frac_sum    = {1'b0, st_q.scaled} + (VB+1)'(frac_add);
	assign scaled_frac = frac_sum[VB] ? ValMax : frac_sum[VB-1:0];

	// Next state for one byte
	always_comb begin
		nx         = st_q;
		nx_comment = in_comment_q;
		if (st_q.err == gawp_pkg::ERR_NONE) begin
			if (item.cls == gawp_pkg::CLS_NEWLINE) begin
				// commits even inside a comment; the comment stays open
				nx = commit_word(nx);
			end else if (in_comment_q) begin
				if (item.cls == gawp_pkg::CLS_CLOSE) begin
					nx_comment = 1'b0;
				end
			end else begin
				case (item.cls)
					gawp_pkg::CLS_OPEN: begin
						nx_comment = 1'b1;
					end
					gawp_pkg::CLS_AXIS: begin
						nx = commit_word(nx);
						if (nx.err == gawp_pkg::ERR_NONE) begin
							nx.open_axis = item.axis;
						end
					end
					gawp_pkg::CLS_DIGIT, gawp_pkg::CLS_POINT: begin
						if (st_q.open_axis == gawp_pkg::AXIS_NONE) begin
							nx.err = gawp_pkg::ERR_NO_AXIS;
						end else if (st_q.word_chars >= WcLimit) begin
							nx.err = gawp_pkg::ERR_TOO_LONG;
						end else begin
							nx.word_chars = st_q.word_chars + WCW'(1);
							if (!st_q.stopped) begin
								if (item.cls == gawp_pkg::CLS_POINT) begin
									// a second point freezes the value
									if (st_q.point_seen) begin
										nx.stopped = 1'b1;
									end else begin
										nx.point_seen = 1'b1;
									end
								end else if (!st_q.point_seen) begin
									nx.scaled = scaled_int;
								end else if (st_q.frac_count < FdCnt) begin
									nx.frac_count = st_q.frac_count + 3'd1;
									nx.scaled     = scaled_frac;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end

		// End of request: final commit, report, then clear all but positions
		if (item.last) begin
			if (nx.err == gawp_pkg::ERR_NONE) begin
				nx = commit_word(nx);
			end
		end
		ext_x   = {{OutPad{1'b0}}, nx.pos_x};
		ext_y   = {{OutPad{1'b0}}, nx.pos_y};
		ext_z   = {{OutPad{1'b0}}, nx.pos_z};
		res.pos_x = ext_x[OutPad-1:0];
		res.pos_y = ext_y[OutPad-1:0];
		res.pos_z = ext_z[OutPad-1:0];
		res.err   = nx.err;
		if (item.last) begin
			nx.open_axis  = gawp_pkg::AXIS_NONE;
			nx.word_chars = '0;
			nx.point_seen = 1'b0;
			nx.stopped    = 1'b0;
			nx.frac_count = 3'd0;
			nx.scaled     = '0;
			nx.err        = gawp_pkg::ERR_NONE;
			nx_comment    = 1'b0;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= '0;
			in_comment_q <= 1'b0;
		end else if (item_take) begin
			st_q         <= nx;
			in_comment_q <= nx_comment;
		end
	end

endmodule

// ----- src/gcode_axis_word_parser.sv -----
// ----------------------------------------------------------------------------
// gcode_axis_word_parser
// G-code X/Y/Z word parser with queue-style byte input and result output.
// ----------------------------------------------------------------------------
// Bytes are pushed one per clock while full is low; the parser sustains one
// byte per cycle while the result queue has room, bounded by the combinational
// multiply-by-ten and add that updates the open value. A byte is classified,
// waits in a two-entry queue and is executed when the executor takes it; a
// byte marked last places its result (X, Y, Z positions in 10^-4 units and
// the error code) in a two-entry result queue, whose head drives the outputs.
// A full result queue holds the executor, and the byte queue then fills and
// raises full. Positions persist across requests; everything else restarts
// after each last byte. After reset no clearing pass is needed.
`include "assert_macros.svh"

module gcode_axis_word_parser #(
	parameter int MAX_WORD_LEN    = gawp_pkg::MaxWordLenDef,
	parameter int FRACTION_DIGITS = gawp_pkg::FractionDigitsDef,
	parameter int VALUE_BITS      = gawp_pkg::ValueBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	output logic                      empty,
	input  logic                      pop,
	output logic [gawp_pkg::OutW-1:0] pos_x,
	output logic [gawp_pkg::OutW-1:0] pos_y,
	output logic [gawp_pkg::OutW-1:0] pos_z,
	output logic [1:0]                error_code
);

	localparam int ResW = $bits(gawp_pkg::result_t);

	gawp_pkg::item_t   item;
	logic              item_valid;
	logic              item_take;
	gawp_pkg::result_t res;
	logic              res_push;
	logic              res_full;
	logic              res_empty;
	logic [ResW-1:0]   res_rd_data;
	gawp_pkg::result_t res_head;

	// Front end: classify and queue
	gawp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.item      (item),
		.item_valid(item_valid),
		.item_take (item_take)
	);

	// Back end: word state and positions
	gawp_exec #(
		.MAX_WORD_LEN   (MAX_WORD_LEN),
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.VALUE_BITS     (VALUE_BITS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_take (item_take),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// Result queue
	gawp_queue #(
		.W(ResW)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.rd_en  (pop),
		.rd_data(res_rd_data),
		.full   (res_full),
		.empty  (res_empty)
	);

	assign res_head   = gawp_pkg::result_t'(res_rd_data);
	assign empty      = res_empty;
	assign pos_x      = res_head.pos_x;
	assign pos_y      = res_head.pos_y;
	assign pos_z      = res_head.pos_z;
	assign error_code = res_head.err;

	// Checks
	`GAWP_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "result written to full queue")
	`GAWP_ASSERT_NEXT(a_last_gives_result, item_take && item.last, !res_empty, "result lost")
	`GAWP_ASSERT_NEXT(a_push_lands, push && !full && !item_valid, item_valid, "byte lost")

endmodule
